### design/aipl_pkg.sv
// Package for the active/inactive page list block: constants, request types and control types.
package aipl_pkg;

	localparam int NUM_PAGES_DEF  = 16;
	localparam int TOTAL_BITS_DEF = 16;
	localparam int CFG_W          = 5;
	localparam int CNT_OUT_W      = 5;
	localparam int PAGE_ID_W      = 4;
	localparam int TOTAL_OUT_W    = 16;

	localparam logic [CFG_W-1:0] ACTIVE_LIMIT_RST = 5'd11;
	localparam logic [CFG_W-1:0] DEMOTE_COUNT_RST = 5'd4;

	// Configuration register indexes.
	localparam logic CFG_ACTIVE_LIMIT = 1'b0;
	localparam logic CFG_DEMOTE_COUNT = 1'b1;

	// Request modes.
	localparam logic [1:0] MODE_REF  = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;

	typedef struct packed {
		logic [1:0]           mode;
		logic [PAGE_ID_W-1:0] page_id;
	} in_item_t;

	typedef struct packed {
		logic [CNT_OUT_W-1:0]   active_count;
		logic [CNT_OUT_W-1:0]   inactive_count;
		logic [CNT_OUT_W-1:0]   demoted;
		logic [CNT_OUT_W-1:0]   counted;
		logic [TOTAL_OUT_W-1:0] page_total;
		logic                   page_active;
		logic                   page_ref;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_REM,
		S_APP,
		S_CHK,
		S_DEM,
		S_TICK,
		S_DRAIN,
		S_RD,
		S_FIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic remove;
		logic append;
		logic demote;
		logic tick_rd;
		logic rd_page;
		logic fin;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] mode;
		logic       page_ok;
		logic       over_limit;
		logic       dem_more;
		logic       tick_last;
		logic       out_free;
	} sts_t;

endpackage

### design/aipl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module aipl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/aipl_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module aipl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  aipl_pkg::sts_t sts,
	output aipl_pkg::cmd_t cmd
);

	import aipl_pkg::*;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.mode == MODE_REF && sts.page_ok) begin
					state_d = S_REM;
				end else if (sts.mode == MODE_TICK) begin
					state_d = S_TICK;
				end else begin
					state_d = S_RD;
				end
			end
			S_REM: begin
				cmd.remove = 1'b1;
				state_d    = S_APP;
			end
			S_APP: begin
				cmd.append = 1'b1;
				state_d    = S_CHK;
			end
			S_CHK: begin
				state_d = sts.over_limit ? S_DEM : S_RD;
			end
			S_DEM: begin
				if (sts.dem_more) begin
					cmd.demote = 1'b1;
				end else begin
					state_d = S_RD;
				end
			end
			S_TICK: begin
				cmd.tick_rd = 1'b1;
				if (sts.tick_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_RD;
			end
			S_RD: begin
				cmd.rd_page = 1'b1;
				state_d     = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// At most one datapath operation is commanded per cycle.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	// A result is only loaded when the output register can take it.
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> sts.out_free)
		else $error("result loaded into a busy output register");

	// A request is taken only from idle and then dispatched.
	a_load_disp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_DISP)
		else $error("accepted request not dispatched");

endmodule

### design/aipl_dp.sv
// Datapath: active list, page flags, reference totals, configuration and result register.
module aipl_dp #(
	parameter int NUM_PAGES  = aipl_pkg::NUM_PAGES_DEF,
	parameter int TOTAL_BITS = aipl_pkg::TOTAL_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  aipl_pkg::in_item_t             in_data,
	input  aipl_pkg::cmd_t                 cmd,
	output aipl_pkg::sts_t                 sts,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [aipl_pkg::CFG_W-1:0]     cfg_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output aipl_pkg::out_item_t            out_data
);

	import aipl_pkg::*;

	localparam int PW = $clog2(NUM_PAGES);
	localparam int CW = $clog2(NUM_PAGES + 1);
	localparam int MW = (CW > CFG_W) ? CW : CFG_W;
	localparam int IW = (PAGE_ID_W > PW + 1) ? PAGE_ID_W : PW + 1;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

	logic [CFG_W-1:0]      limit_q, demote_q;
	logic [1:0]            mode_q;
	logic [PW-1:0]         page_q;
	logic                  page_ok_q;
	logic [PW-1:0]         list_q [NUM_PAGES];
	logic [CW-1:0]         len_q;
	logic [NUM_PAGES-1:0]  act_q, ref_q, tvalid_q;
	logic [CW-1:0]         dem_q, cnt_q;
	logic [PW-1:0]         tidx_q;
	logic                  tick_v_s1;
	logic [PW-1:0]         tick_p_s1;
	logic                  out_valid_q;
	out_item_t             out_q;
	logic [NUM_PAGES-1:0]  after;
	logic                  run;
	logic [TOTAL_BITS-1:0] rdata, tot_s1;
	logic                  bump;
	logic                  ram_re;
	logic [PW-1:0]         ram_raddr;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= ACTIVE_LIMIT_RST;
			demote_q <= DEMOTE_COUNT_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ACTIVE_LIMIT) begin
				limit_q <= cfg_data;
			end else begin
				demote_q <= cfg_data;
			end
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q     <= in_data.mode;
			page_q     <= PW'(in_data.page_id);
			page_ok_q  <= IW'(in_data.page_id) < IW'(NUM_PAGES);
		end
	end

	// Entries at or after the referenced page's position in the active list.
	always_comb begin
		run = 1'b0;
		for (int i = 0; i < NUM_PAGES; i++) begin
			run      = run | ((list_q[i] == page_q) && (CW'(i) < len_q));
			after[i] = run;
		end
	end

	// Active list: removal, append at tail and pop from head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PAGES; i++) begin
				list_q[i] <= PW'(i);
			end
			len_q <= CW'(NUM_PAGES);
			act_q <= '1;
			dem_q <= '0;
		end else begin
			if (cmd.load) begin
				dem_q <= '0;
			end
			if (cmd.remove && act_q[page_q]) begin
				for (int i = 0; i < NUM_PAGES - 1; i++) begin
					if (after[i]) begin
						list_q[i] <= list_q[i+1];
					end
				end
				len_q         <= len_q - 1'b1;
				act_q[page_q] <= 1'b0;
			end
			if (cmd.append) begin
				for (int i = 0; i < NUM_PAGES; i++) begin
					if (CW'(i) == len_q) begin
						list_q[i] <= page_q;
					end
				end
				len_q         <= len_q + 1'b1;
				act_q[page_q] <= 1'b1;
			end
			if (cmd.demote) begin
				for (int i = 0; i < NUM_PAGES - 1; i++) begin
					list_q[i] <= list_q[i+1];
				end
				act_q[list_q[0]] <= 1'b0;
				len_q            <= len_q - 1'b1;
				dem_q            <= dem_q + 1'b1;
			end
		end
	end

	// Reference totals live in RAM; a page reads as zero until first written.
	assign ram_re    = cmd.tick_rd | cmd.rd_page;
	assign ram_raddr = cmd.rd_page ? page_q : tidx_q;
	assign tot_s1    = tvalid_q[tick_p_s1] ? rdata : '0;
	assign bump      = tick_v_s1 && act_q[tick_p_s1] && ref_q[tick_p_s1]
		&& (tot_s1 != TOTAL_MAX);

	aipl_ram #(
		.WIDTH (TOTAL_BITS),
		.DEPTH (NUM_PAGES)
	) u_totals (
		.clk   (clk),
		.we    (bump),
		.waddr (tick_p_s1),
		.wdata (tot_s1 + 1'b1),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// Reference bits and the checker tick walk, one page id per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q     <= '0;
			tvalid_q  <= '0;
			tidx_q    <= '0;
			tick_v_s1 <= 1'b0;
			cnt_q     <= '0;
		end else begin
			tick_v_s1 <= cmd.tick_rd;
			if (cmd.load) begin
				tidx_q <= '0;
				cnt_q  <= '0;
			end
			if (cmd.tick_rd) begin
				tidx_q <= tidx_q + 1'b1;
			end
			if (cmd.remove) begin
				ref_q[page_q] <= 1'b1;
			end
			if (tick_v_s1 && act_q[tick_p_s1] && ref_q[tick_p_s1]) begin
				ref_q[tick_p_s1] <= 1'b0;
			end
			if (bump) begin
				tvalid_q[tick_p_s1] <= 1'b1;
				cnt_q               <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		tick_p_s1 <= tidx_q;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_q.active_count   <= CNT_OUT_W'(len_q);
			out_q.inactive_count <= CNT_OUT_W'(CW'(NUM_PAGES) - len_q);
			out_q.demoted        <= CNT_OUT_W'(dem_q);
			out_q.counted        <= CNT_OUT_W'(cnt_q);
			out_q.page_total     <= (page_ok_q && tvalid_q[page_q])
				? TOTAL_OUT_W'(rdata) : '0;
			out_q.page_active    <= page_ok_q & act_q[page_q];
			out_q.page_ref       <= page_ok_q & ref_q[page_q];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Status to the controller.
	always_comb begin
		sts.mode       = mode_q;
		sts.page_ok    = page_ok_q;
		sts.over_limit = MW'(len_q) > MW'(limit_q);
		sts.dem_more   = (MW'(dem_q) < MW'(demote_q)) && (len_q != '0);
		sts.tick_last  = tidx_q == PW'(NUM_PAGES - 1);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	// The active length always equals the number of pages flagged active.
	a_len_flags: assert property (@(posedge clk) disable iff (!arst_n)
		len_q == CW'($countones(act_q)))
		else $error("active length disagrees with active flags");

	// The active list never holds more than all pages.
	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CW'(NUM_PAGES))
		else $error("active length beyond page count");

	// Each demotion shortens the active list by one.
	a_demote_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.demote |=> len_q == $past(len_q) - 1'b1)
		else $error("demotion did not shorten the active list");

endmodule

### design/active_inactive_page_lists.sv
// Top level of the two-list page reclamation block.
// Keeps NUM_PAGES pages on an ordered active list and an inactive list, with a reference
// bit and a saturating TOTAL_BITS reference total per page; every page starts active in id
// order. Each request returns one result. A reference demotes no page when the active count
// stays within active_limit, and otherwise demotes pages from the head of the active list,
// at most demote_count of them; a checker tick walks over all page ids through the single
// read port of the totals RAM; a query only reads the state of its page. A stalled result
// holds up the block only when the next result is ready to be loaded. One request
// is worked on at a time, and the next one is taken as soon as its result sits in the
// output register, even if that result is still stalled. There is no clearing pass after
// reset; the block takes requests right away.
module active_inactive_page_lists #(
	parameter int NUM_PAGES  = aipl_pkg::NUM_PAGES_DEF,
	parameter int TOTAL_BITS = aipl_pkg::TOTAL_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  aipl_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output aipl_pkg::out_item_t        out_data,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [aipl_pkg::CFG_W-1:0] cfg_data
);

	import aipl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	aipl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// List, flag and total storage.
	aipl_dp #(
		.NUM_PAGES  (NUM_PAGES),
		.TOTAL_BITS (TOTAL_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### tb/tb_active_inactive_page_lists.sv
// Self-checking testbench for the two-list page reclamation block.
module tb_active_inactive_page_lists;
	timeunit 1ns;
	timeprecision 1ps;
	import aipl_pkg::*;

	localparam int PAGES = 16;
	localparam logic [1:0] MODE_QUERY = 2'd2;
	localparam logic [1:0] MODE_ALT = 2'd3;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_data;

	active_inactive_page_lists dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state: both lists, reference bits, totals and registers.
	logic [3:0] act_list[PAGES];
	int act_len;
	logic [3:0] inact_list[PAGES];
	int inact_len;
	logic ref_bit[PAGES];
	logic [15:0] ref_total[PAGES];
	logic [4:0] limit_reg;
	logic [4:0] demote_reg;

	out_item_t expected_q[$];
	int mismatches;
	int results_seen;
	int sent_count;
	int cycles;
	int tick_count;
	int demote_events;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Position of a page on a list, or the list length if absent.
	function automatic int find_page(ref logic [3:0] lst[PAGES], input int len,
			input logic [3:0] pg);
		for (int i = 0; i < len; i++)
			if (lst[i] == pg)
				return i;
		return len;
	endfunction

	function automatic void drop_at(ref logic [3:0] lst[PAGES], ref int len, input int pos);
		if (pos >= len)
			return;
		for (int i = pos; i + 1 < len; i++)
			lst[i] = lst[i + 1];
		len--;
	endfunction

	// Apply one request to the predictor and return the result it should produce.
	function automatic out_item_t predict_result(in_item_t req);
		out_item_t r;
		int pos;
		logic [3:0] front;
		logic [3:0] pg;
		pg = req.page_id;
		r = '0;
		if (req.mode == MODE_REF) begin
			ref_bit[pg] = 1'b1;
			pos = find_page(act_list, act_len, pg);
			drop_at(act_list, act_len, pos);
			pos = find_page(inact_list, inact_len, pg);
			drop_at(inact_list, inact_len, pos);
			act_list[act_len] = pg;
			act_len++;
			if (act_len > limit_reg) begin
				for (int i = 0; i < demote_reg && act_len > 0; i++) begin
					front = act_list[0];
					drop_at(act_list, act_len, 0);
					inact_list[inact_len] = front;
					inact_len++;
					r.demoted++;
				end
			end
		end else if (req.mode == MODE_TICK) begin
			for (int i = 0; i < act_len; i++) begin
				if (ref_bit[act_list[i]]) begin
					if (ref_total[act_list[i]] != 16'hFFFF) begin
						ref_total[act_list[i]]++;
						r.counted++;
					end
					ref_bit[act_list[i]] = 1'b0;
				end
			end
		end
		r.active_count = act_len[4:0];
		r.inactive_count = inact_len[4:0];
		r.page_total = ref_total[pg];
		r.page_active = find_page(act_list, act_len, pg) < act_len;
		r.page_ref = ref_bit[pg];
		return r;
	endfunction

	// Receiver: random stall pattern and result comparison.
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h", out_data);
				end else begin
					exp_r = expected_q.pop_front();
					if (out_data !== exp_r) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result %0d: expected act=%0d inact=%0d dem=%0d",
								" cnt=%0d tot=%0d a=%0b r=%0b, got act=%0d inact=%0d",
								" dem=%0d cnt=%0d tot=%0d a=%0b r=%0b"},
								results_seen, exp_r.active_count, exp_r.inactive_count,
								exp_r.demoted, exp_r.counted, exp_r.page_total,
								exp_r.page_active, exp_r.page_ref, out_data.active_count,
								out_data.inactive_count, out_data.demoted, out_data.counted,
								out_data.page_total, out_data.page_active, out_data.page_ref);
					end
				end
			end
			out_stall <= ((cycles / 200) % 3 == 0) ? 1'b0 : ($urandom_range(0, 3) == 0);
		end
	end

	// Cycle counter with a hard limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Send one request, with a random gap before it when bursting ends.
	int burst_left;
	task automatic send_request(input logic [1:0] md, input logic [3:0] pg);
		in_item_t req;
		logic stalled;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		req.mode = md;
		req.page_id = pg;
		in_valid <= 1'b1;
		in_data <= req;
		// The stall is sampled between edges, where it is settled.
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		expected_q.push_back(predict_result(req));
		sent_count++;
		if (md == MODE_TICK)
			tick_count++;
		if (expected_q[$].demoted != 0)
			demote_events++;
	endtask

	// Wait for all results, then allow the block to settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [4:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ACTIVE_LIMIT)
			limit_reg = val;
		else
			demote_reg = val;
	endtask

	task automatic test_directed();
		send_request(MODE_QUERY, 4'd0);
		send_request(MODE_TICK, 4'd15);
		send_request(MODE_REF, 4'd0);
		send_request(MODE_REF, 4'd15);
		send_request(MODE_REF, 4'd7);
		send_request(MODE_ALT, 4'd7);
		send_request(MODE_TICK, 4'd7);
		send_request(MODE_REF, 4'd1);
		send_request(MODE_REF, 4'd3);
		send_request(MODE_QUERY, 4'd15);
		send_request(MODE_TICK, 4'd0);
		drain();
	endtask

	// Registers at the extremes: never demote, then empty on every reference.
	task automatic test_extremes();
		write_reg(CFG_ACTIVE_LIMIT, 5'd16);
		write_reg(CFG_DEMOTE_COUNT, 5'd16);
		for (int i = 0; i < 6; i++)
			send_request(MODE_REF, 4'($urandom_range(0, 15)));
		drain();
		write_reg(CFG_ACTIVE_LIMIT, 5'd0);
		write_reg(CFG_DEMOTE_COUNT, 5'd31);
		for (int i = 0; i < 6; i++)
			send_request(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
		drain();
		write_reg(CFG_DEMOTE_COUNT, 5'd0);
		send_request(MODE_REF, 4'd9);
		send_request(MODE_TICK, 4'd9);
		drain();
	endtask

	// Random requests over several register settings, mostly references and ticks.
	task automatic test_random(input int n_items);
		int sel;
		logic [1:0] md;
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(CFG_ACTIVE_LIMIT, 5'($urandom_range(0, 17)));
			write_reg(CFG_DEMOTE_COUNT, 5'($urandom_range(0, 17)));
			for (int i = 0; i < n_items / 5; i++) begin
				sel = $urandom_range(0, 9);
				md = (sel < 6) ? MODE_REF : (sel < 8) ? MODE_TICK : 2'($urandom_range(2, 3));
				send_request(md, 4'($urandom));
			end
			drain();
		end
		write_reg(CFG_ACTIVE_LIMIT, ACTIVE_LIMIT_RST);
		write_reg(CFG_DEMOTE_COUNT, DEMOTE_COUNT_RST);
		for (int i = 0; i < 60; i++)
			send_request(2'($urandom), 4'($urandom));
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ACTIVE_LIMIT;
		cfg_data = '0;
		mismatches = 0;
		results_seen = 0;
		sent_count = 0;
		cycles = 0;
		tick_count = 0;
		demote_events = 0;
		burst_left = 0;
		limit_reg = ACTIVE_LIMIT_RST;
		demote_reg = DEMOTE_COUNT_RST;
		act_len = PAGES;
		inact_len = 0;
		for (int i = 0; i < PAGES; i++) begin
			act_list[i] = 4'(i);
			inact_list[i] = '0;
			ref_bit[i] = 1'b0;
			ref_total[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_extremes();
		test_random(640);
		$display("Covered %0d requests (%0d ticks, %0d demoting references), %0d results.",
			sent_count, tick_count, demote_events, results_seen);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
